>>> design/pds_pkg.sv
package pds_pkg;

    // Field widths of the stream items and registers
    localparam int PIX_W    = 32;
    localparam int LANE_W   = 33;
    localparam int CFG_W    = 34;
    localparam int REF_W    = 32;
    localparam int FACTOR_W = 8;
    localparam int DIV_W    = 4;
    localparam int PLL_W    = 33;
    localparam int VCO_W    = 34;
    localparam int MI_W     = 10;
    localparam int MF_W     = 17;

    // Search limits
    localparam int OD_STAGES  = 3;
    localparam int MAX_FACTOR = 255;
    localparam int FRAC_SCALE = 131072;
    localparam int FRAC_BITS  = $clog2(FRAC_SCALE);

    // Divider exponent per stage runs from OD_STAGES-1 down to 0
    localparam int OD_EXP_W   = (OD_STAGES > 1) ? $clog2(OD_STAGES) : 1;
    localparam int SHIFT_MAX  = 3 * (OD_STAGES - 1);
    localparam int SHIFT_W    = (SHIFT_MAX > 0) ? $clog2(SHIFT_MAX + 1) : 1;

    // Running product pix * factor, and its shifted form for the window check
    localparam int PLL_ACC_W  = PIX_W + FACTOR_W;
    localparam int VCO_CMP_W  = PLL_ACC_W + SHIFT_MAX;

    // Long division of vco * FRAC_SCALE by the reference clock
    localparam int QUOT_W     = MI_W + FRAC_BITS;
    localparam int DIV_STEPS  = VCO_W + FRAC_BITS;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);

    // Stream payload layout
    localparam int IN_FIELDS_W  = PIX_W + LANE_W;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = 2 + FACTOR_W + 3 * DIV_W + PLL_W + VCO_W + MI_W + MF_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    // Configuration register indexes
    localparam logic [1:0] CFG_MAX_PIX = 2'd0;
    localparam logic [1:0] CFG_VCO_MIN = 2'd1;
    localparam logic [1:0] CFG_VCO_MAX = 2'd2;
    localparam logic [1:0] CFG_REF_CLK = 2'd3;

    localparam logic [PIX_W-1:0] RST_MAX_PIX = PIX_W'(200000000);
    localparam logic [VCO_W-1:0] RST_VCO_MIN = VCO_W'(64'd3000000000);
    localparam logic [VCO_W-1:0] RST_VCO_MAX = VCO_W'(64'd6000000000);
    localparam logic [REF_W-1:0] RST_REF_CLK = REF_W'(24000000);

    typedef enum logic [1:0] {
        STAT_OK     = 2'd0,
        STAT_RANGE  = 2'd1,
        STAT_NO_SOL = 2'd2
    } t_status;

    typedef struct packed {
        t_status             status;
        logic [FACTOR_W-1:0] factor;
        logic [DIV_W-1:0]    div1;
        logic [DIV_W-1:0]    div2;
        logic [DIV_W-1:0]    div3;
        logic [PLL_W-1:0]    pll;
        logic [VCO_W-1:0]    vco;
    } t_srch_res;

    typedef struct packed {
        logic [MI_W-1:0] mult_int;
        logic [MF_W-1:0] mult_frac;
    } t_mult_res;

endpackage

>>> design/pll_divider_search_unit.sv
// PLL divider search. An input transfer carries a pixel clock and a maximum lane
// bit rate; one result transfer follows. Pixel clocks above the configured limit
// come back as out of range. Otherwise a sequencer walks clock factors 1..255
// through one shared add-and-compare unit; each factor whose PLL output falls in
// the lane window then tries up to ten divider combinations on the same unit. The
// walk stops early once the PLL output passes the lane rate. A found setting then
// goes through a bit-serial divider for the multiplier against the reference
// clock. The worst case is reached when every factor lands in the lane window
// (zero pixel clock and zero lane rate) and no setting is found; the input is not
// ready until the result is loaded into the output register. The output is
// registered, so the next item may enter while a result waits. Configuration
// writes must only be issued while the block is idle.
module pll_divider_search_unit import pds_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [1:0]             i_cfg_idx,
    input  logic [CFG_W-1:0]       i_cfg_data,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // pixel_clock_hz, max_lane_bit_rate_hz, zero fill
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // status, freq_factor, out_div1, out_div2, out_div3, pll_out_hz, vco_hz,
    // mult_integer, mult_fraction, zero fill
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_DIV,
        ST_OUT
    } t_state;

    t_state                  r_state;
    logic [PIX_W-1:0]        r_max_pix;
    logic [VCO_W-1:0]        r_vco_min;
    logic [VCO_W-1:0]        r_vco_max;
    logic [REF_W-1:0]        r_ref_clk;
    t_srch_res               r_res;
    t_mult_res               r_mult;
    logic                    r_m_tvalid;
    logic [OUT_TDATA_W-1:0]  r_m_tdata;

    logic                    srch_start;
    logic                    srch_done;
    t_srch_res               srch_res;
    logic                    div_start;
    logic                    div_done;
    t_mult_res               div_res;
    logic                    out_load;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign srch_start    = s_axis_tvalid && s_axis_tready;
    assign div_start     = (r_state == ST_SEARCH) && srch_done && (srch_res.status == STAT_OK);
    assign out_load      = (r_state == ST_OUT) && (!r_m_tvalid || m_axis_tready);

    pds_search u_search (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (srch_start),
        .i_pix     (s_axis_tdata[PIX_W-1:0]),
        .i_lane    (s_axis_tdata[PIX_W+LANE_W-1:PIX_W]),
        .i_max_pix (r_max_pix),
        .i_vco_min (r_vco_min),
        .i_vco_max (r_vco_max),
        .o_done    (srch_done),
        .o_res     (srch_res)
    );

    pds_divider u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (srch_res.vco),
        .i_divisor  (r_ref_clk),
        .o_done     (div_done),
        .o_res      (div_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_pix <= RST_MAX_PIX;
            r_vco_min <= RST_VCO_MIN;
            r_vco_max <= RST_VCO_MAX;
            r_ref_clk <= RST_REF_CLK;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MAX_PIX: r_max_pix <= i_cfg_data[PIX_W-1:0];
                CFG_VCO_MIN: r_vco_min <= i_cfg_data[VCO_W-1:0];
                CFG_VCO_MAX: r_vco_max <= i_cfg_data[VCO_W-1:0];
                CFG_REF_CLK: r_ref_clk <= i_cfg_data[REF_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_m_tvalid <= 1'b0;
        end else begin
            if (out_load) begin
                r_m_tvalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_tvalid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (srch_start) begin
                        r_state <= ST_SEARCH;
                    end
                end
                ST_SEARCH: begin
                    if (srch_done) begin
                        r_res   <= srch_res;
                        r_mult  <= '0;
                        r_state <= (srch_res.status == STAT_OK) ? ST_DIV : ST_OUT;
                    end
                end
                ST_DIV: begin
                    if (div_done) begin
                        r_mult  <= div_res;
                        r_state <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    // load once the output register is free or being drained
                    if (out_load) begin
                        r_m_tdata  <= OUT_TDATA_W'({r_mult.mult_frac, r_mult.mult_int,
                                                    r_res.vco, r_res.pll, r_res.div3,
                                                    r_res.div2, r_res.div1, r_res.factor,
                                                    r_res.status});
                        r_state    <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_m_tvalid;
    assign m_axis_tdata  = r_m_tdata;

`ifndef SYNTHESIS
    a_srch_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        srch_done |-> (r_state == ST_SEARCH))
        else $error("search finished outside the search phase");

    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == ST_DIV))
        else $error("divider finished outside the divide phase");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (srch_done && (srch_res.status != STAT_OK)) |->
            (srch_res.factor == '0 && srch_res.vco == '0 && srch_res.pll == '0))
        else $error("error result carries nonzero fields");

    a_vco_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (srch_done && (srch_res.status == STAT_OK)) |->
            (srch_res.vco >= r_vco_min && srch_res.vco <= r_vco_max && srch_res.factor != '0))
        else $error("accepted setting outside the VCO window");
`endif

endmodule

>>> design/pds_search.sv
module pds_search import pds_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [PIX_W-1:0]    i_pix,
    input  logic [LANE_W-1:0]   i_lane,
    input  logic [PIX_W-1:0]    i_max_pix,
    input  logic [VCO_W-1:0]    i_vco_min,
    input  logic [VCO_W-1:0]    i_vco_max,
    output logic                o_done,
    output t_srch_res           o_res
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_FACTOR,
        S_DIVS,
        S_DONE
    } t_state;

    localparam logic [OD_EXP_W-1:0] OD_TOP = OD_EXP_W'(OD_STAGES - 1);

    t_state                r_state;
    t_status               r_status;
    logic [PIX_W-1:0]      r_pix;
    logic [LANE_W-1:0]     r_lane_max;
    logic [LANE_W-1:0]     r_lane_min;
    logic [PLL_ACC_W-1:0]  r_pll;
    logic [FACTOR_W-1:0]   r_factor;
    logic [OD_EXP_W-1:0]   r_e1;
    logic [OD_EXP_W-1:0]   r_e2;
    logic [OD_EXP_W-1:0]   r_e3;

    logic [SHIFT_W-1:0]    shamt;
    logic [VCO_CMP_W-1:0]  vco_cmp;
    logic                  in_window;
    logic                  pll_over;
    logic                  pll_in;
    logic                  last_factor;

    // Shared shift and compare: dividers are powers of two
    always_comb begin
        shamt     = SHIFT_W'(r_e1) + SHIFT_W'(r_e2) + SHIFT_W'(r_e3);
        vco_cmp   = VCO_CMP_W'(r_pll) << shamt;
        in_window = (vco_cmp >= VCO_CMP_W'(i_vco_min)) && (vco_cmp <= VCO_CMP_W'(i_vco_max));
        pll_over  = r_pll > PLL_ACC_W'(r_lane_max);
        pll_in    = r_pll >= PLL_ACC_W'(r_lane_min);
        last_factor = (r_factor == FACTOR_W'(MAX_FACTOR));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_status <= STAT_OK;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_pix      <= i_pix;
                        r_lane_max <= i_lane;
                        r_lane_min <= (i_lane > LANE_W'(i_pix)) ? i_lane - LANE_W'(i_pix) : '0;
                        r_pll      <= PLL_ACC_W'(i_pix);
                        r_factor   <= FACTOR_W'(1);
                        if (i_pix > i_max_pix) begin
                            r_status <= STAT_RANGE;
                            r_state  <= S_DONE;
                        end else begin
                            r_state  <= S_FACTOR;
                        end
                    end
                end
                S_FACTOR: begin
                    // pll only grows with the factor: stop once past the lane rate
                    if (pll_over) begin
                        r_status <= STAT_NO_SOL;
                        r_state  <= S_DONE;
                    end else if (pll_in) begin
                        r_e1    <= OD_TOP;
                        r_e2    <= OD_TOP;
                        r_e3    <= OD_TOP;
                        r_state <= S_DIVS;
                    end else if (last_factor) begin
                        r_status <= STAT_NO_SOL;
                        r_state  <= S_DONE;
                    end else begin
                        r_pll    <= r_pll + PLL_ACC_W'(r_pix);
                        r_factor <= r_factor + FACTOR_W'(1);
                    end
                end
                S_DIVS: begin
                    if (in_window) begin
                        r_status <= STAT_OK;
                        r_state  <= S_DONE;
                    end else if (r_e1 != '0) begin
                        r_e1 <= r_e1 - OD_EXP_W'(1);
                    end else if (r_e2 != '0) begin
                        r_e2 <= r_e2 - OD_EXP_W'(1);
                        r_e1 <= r_e2 - OD_EXP_W'(1);
                    end else if (r_e3 != '0) begin
                        r_e3 <= r_e3 - OD_EXP_W'(1);
                        r_e2 <= r_e3 - OD_EXP_W'(1);
                        r_e1 <= r_e3 - OD_EXP_W'(1);
                    end else if (last_factor) begin
                        r_status <= STAT_NO_SOL;
                        r_state  <= S_DONE;
                    end else begin
                        r_pll    <= r_pll + PLL_ACC_W'(r_pix);
                        r_factor <= r_factor + FACTOR_W'(1);
                        r_state  <= S_FACTOR;
                    end
                end
                S_DONE: begin
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_done = (r_state == S_DONE);

    always_comb begin
        o_res        = '0;
        o_res.status = r_status;
        if (r_status == STAT_OK) begin
            o_res.factor = r_factor;
            o_res.div1   = DIV_W'(1) << r_e1;
            o_res.div2   = DIV_W'(1) << r_e2;
            o_res.div3   = DIV_W'(1) << r_e3;
            o_res.pll    = r_pll[PLL_W-1:0];
            o_res.vco    = vco_cmp[VCO_W-1:0];
        end
    end

endmodule

>>> design/pds_divider.sv
module pds_divider import pds_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [VCO_W-1:0]  i_dividend,
    input  logic [REF_W-1:0]  i_divisor,
    output logic              o_done,
    output t_mult_res         o_res
);

    logic                  r_busy;
    logic                  r_done;
    logic [DIV_CNT_W-1:0]  r_cnt;
    logic [VCO_W-1:0]      r_dvd;
    logic [REF_W-1:0]      r_rem;
    logic [QUOT_W-1:0]     r_quot;
    logic                  r_ovf;
    logic                  r_zero;

    logic [REF_W:0]        rem_sh;
    logic                  ge;
    logic [REF_W:0]        rem_nx;

    // One restoring step: bring down the next dividend bit (zeros after vco)
    always_comb begin
        rem_sh = {r_rem, r_dvd[VCO_W-1]};
        ge     = rem_sh >= (REF_W+1)'(i_divisor);
        rem_nx = ge ? rem_sh - (REF_W+1)'(i_divisor) : rem_sh;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(DIV_STEPS - 1);
                r_dvd  <= i_dividend;
                r_rem  <= '0;
                r_quot <= '0;
                r_ovf  <= 1'b0;
                r_zero <= (i_divisor == '0);
            end else if (r_busy) begin
                r_dvd  <= {r_dvd[VCO_W-2:0], 1'b0};
                r_rem  <= rem_nx[REF_W-1:0];
                r_quot <= {r_quot[QUOT_W-2:0], ge};
                // any quotient bit above the integer field saturates
                r_ovf  <= r_ovf | r_quot[QUOT_W-1];
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - DIV_CNT_W'(1);
                end
            end
        end
    end

    assign o_done = r_done;

    always_comb begin
        if (r_zero) begin
            o_res.mult_int  = '1;
            o_res.mult_frac = '0;
        end else begin
            o_res.mult_int  = r_ovf ? '1 : r_quot[QUOT_W-1:FRAC_BITS];
            o_res.mult_frac = MF_W'(r_quot[FRAC_BITS-1:0]);
        end
    end

endmodule
